FILE: hdl/dltq_pkg.sv
// ----------------------------------------------------------------------------
// Delta-list timer queue package
// Request and result codes, transaction structs, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int FIRED_W     = 5;

  typedef enum logic [2:0] {
    REQ_TICK       = 3'd0,
    REQ_POST       = 3'd1,
    REQ_RESTART    = 3'd2,
    REQ_REMOVE     = 3'd3,
    REQ_REMOVE_ALL = 3'd4,
    REQ_QUERY      = 3'd5
  } req_type_t;

  typedef enum logic [2:0] {
    RES_POST_ACK  = 3'd0,
    RES_EXPIRY    = 3'd1,
    RES_REMOVED   = 3'd2,
    RES_QUERY     = 3'd3,
    RES_TICK_IDLE = 3'd4
  } result_kind_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  task_id;
    logic [15:0] delay;
    logic [15:0] repeat_period;
    logic [15:0] task_param;
  } req_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic        ok;
    logic [4:0]  removed_count;
    logic [7:0]  fired_task;
    logic [15:0] fired_param;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_CHECK,
    ST_POST_WALK,
    ST_REMOVE_WALK,
    ST_QUERY_WALK
  } state_t;

  typedef struct packed {
    logic load_req;
    logic load_head;
    logic tick_dec;
    logic k_clr;
    logic k_inc;
    logic rest_sub;
    logic insert;
    logic drop;
    logic drop_head;
    logic clear_all;
  } cmd_t;

  typedef struct packed {
    logic        k_lt_count;
    logic        full;
    logic        rest_gt;
    logic        id_match;
    logic        head_zero;
    logic        head_rep_nz;
    logic [7:0]  op_task;
    logic [15:0] op_param;
  } stat_t;

endpackage

FILE: hdl/dltq_datapath.sv
// ----------------------------------------------------------------------------
// Delta-list timer queue datapath
// Holds the sorted entry registers, the walk index, the remaining delay and
// the operand registers, and carries out insert, drop and tick commands.
// ----------------------------------------------------------------------------
module dltq_datapath
  import dltq_pkg::*;
#(
  parameter int TIMER_SLOTS = 16,
  parameter int COUNT_BITS  = 16,
  parameter int PARAM_BITS  = 16,
  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1,
  localparam int CNT_W = $clog2(TIMER_SLOTS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  req_t             req,
  input  cmd_t             cmd,
  output stat_t            stat,
  output logic [CNT_W-1:0] count
);

  logic [COUNT_BITS-1:0] dlt [TIMER_SLOTS];
  logic [COUNT_BITS-1:0] rep [TIMER_SLOTS];
  logic [7:0]            tsk [TIMER_SLOTS];
  logic [PARAM_BITS-1:0] prm [TIMER_SLOTS];

  logic [CNT_W-1:0]      k;
  logic [COUNT_BITS-1:0] rest;
  logic [7:0]            op_task;
  logic [COUNT_BITS-1:0] op_rep;
  logic [PARAM_BITS-1:0] op_prm;

  logic [IDX_W-1:0]      k_idx;
  logic [IDX_W-1:0]      j_idx;
  logic [IDX_W-1:0]      j1_idx;
  logic [COUNT_BITS-1:0] dlt_k;
  logic [COUNT_BITS:0]   drop_sum;
  logic [COUNT_BITS-1:0] drop_sat;
  logic [COUNT_BITS-1:0] split_dlt;

  assign k_idx     = k[IDX_W-1:0];
  assign j_idx     = cmd.drop_head ? '0 : k_idx;
  assign j1_idx    = j_idx + IDX_W'(1);
  assign dlt_k     = dlt[k_idx];
  assign drop_sum  = {1'b0, dlt[j_idx]} + {1'b0, dlt[j1_idx]};
  assign drop_sat  = drop_sum[COUNT_BITS] ? '1 : drop_sum[COUNT_BITS-1:0];
  // The entry that the new timer lands in front of keeps only what is left.
  assign split_dlt = dlt_k - rest;

  for (genvar m = 0; m < TIMER_SLOTS; m++) begin : g_entry
    logic [COUNT_BITS-1:0] up_dlt, up_rep, dn_dlt, dn_rep;
    logic [7:0]            up_tsk, dn_tsk;
    logic [PARAM_BITS-1:0] up_prm, dn_prm;

    if (m > 0) begin : g_up
      assign up_dlt = dlt[m-1];
      assign up_rep = rep[m-1];
      assign up_tsk = tsk[m-1];
      assign up_prm = prm[m-1];
    end else begin : g_up0
      assign up_dlt = dlt[m];
      assign up_rep = rep[m];
      assign up_tsk = tsk[m];
      assign up_prm = prm[m];
    end

    if (m < TIMER_SLOTS - 1) begin : g_dn
      assign dn_dlt = dlt[m+1];
      assign dn_rep = rep[m+1];
      assign dn_tsk = tsk[m+1];
      assign dn_prm = prm[m+1];
    end else begin : g_dn_last
      assign dn_dlt = dlt[m];
      assign dn_rep = rep[m];
      assign dn_tsk = tsk[m];
      assign dn_prm = prm[m];
    end

    always_ff @(posedge clk) begin
      if (cmd.insert) begin
        if (CNT_W'(m) == k) begin
          dlt[m] <= rest;
          rep[m] <= op_rep;
          tsk[m] <= op_task;
          prm[m] <= op_prm;
        end else if (CNT_W'(m) > k) begin
          dlt[m] <= (CNT_W'(m) == k + CNT_W'(1)) ? split_dlt : up_dlt;
          rep[m] <= up_rep;
          tsk[m] <= up_tsk;
          prm[m] <= up_prm;
        end
      end else if (cmd.drop) begin
        if (IDX_W'(m) >= j_idx) begin
          dlt[m] <= (IDX_W'(m) == j_idx) ? drop_sat : dn_dlt;
          rep[m] <= dn_rep;
          tsk[m] <= dn_tsk;
          prm[m] <= dn_prm;
        end
      end else if (m == 0 && cmd.tick_dec && count != '0 && dlt[m] != '0) begin
        dlt[m] <= dlt[m] - COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear_all) begin
      count <= '0;
    end else if (cmd.insert) begin
      count <= count + CNT_W'(1);
    end else if (cmd.drop) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.k_clr) begin
      k <= '0;
    end else if (cmd.k_inc) begin
      k <= k + CNT_W'(1);
    end
    if (cmd.load_req) begin
      rest    <= COUNT_BITS'(req.delay);
      op_task <= req.task_id;
      op_rep  <= COUNT_BITS'(req.repeat_period);
      op_prm  <= PARAM_BITS'(req.task_param);
    end else if (cmd.load_head) begin
      rest    <= rep[0];
      op_task <= tsk[0];
      op_rep  <= rep[0];
      op_prm  <= prm[0];
    end else if (cmd.rest_sub) begin
      rest <= rest - dlt_k;
    end
  end

  logic [31:0] prm_wide;
  assign prm_wide = 32'(op_prm);

  always_comb begin
    stat.k_lt_count  = (k < count);
    stat.full        = (count == CNT_W'(TIMER_SLOTS));
    stat.rest_gt     = (rest > dlt_k);
    stat.id_match    = (tsk[k_idx] == op_task);
    stat.head_zero   = (count != '0) && (dlt[0] == '0);
    stat.head_rep_nz = (rep[0] != '0);
    stat.op_task     = op_task;
    stat.op_param    = prm_wide[15:0];
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TIMER_SLOTS))
    else $error("entry count beyond the number of slots");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.insert && !cmd.clear_all |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not add one entry");

  a_no_insert_full: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !stat.full)
    else $error("insert into a full list");

endmodule

FILE: hdl/dltq_ctrl.sv
// ----------------------------------------------------------------------------
// Delta-list timer queue controller
// Sequences each request over the list walk and drives the result register.
// ----------------------------------------------------------------------------
module dltq_ctrl
  import dltq_pkg::*;
#(
  parameter int TIMER_SLOTS = 16,
  localparam int CNT_W = $clog2(TIMER_SLOTS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  req_t             req,
  output logic             busy,
  output logic             strobe,
  output result_t          result,
  output cmd_t             cmd,
  input  stat_t            stat,
  input  logic [CNT_W-1:0] count
);

  state_t           state, state_next;
  logic [2:0]       req_kind, req_kind_next;
  logic [CNT_W-1:0] rm_cnt, rm_cnt_next;
  logic [FIRED_W-1:0] fired, fired_next;
  logic             pend, pend_next;
  logic             tick_mode, tick_mode_next;
  logic             emit;
  result_t          res_next;

  function automatic logic [4:0] sat5(input logic [CNT_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'd31) ? 5'd31 : w[4:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit;
    end
    req_kind  <= req_kind_next;
    rm_cnt    <= rm_cnt_next;
    fired     <= fired_next;
    pend      <= pend_next;
    tick_mode <= tick_mode_next;
    if (emit) begin
      result <= res_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next     = state;
    req_kind_next  = req_kind;
    rm_cnt_next    = rm_cnt;
    fired_next     = fired;
    pend_next      = pend;
    tick_mode_next = tick_mode;
    cmd            = '0;
    emit           = 1'b0;
    res_next       = '0;
    res_next.last  = 1'b1;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          req_kind_next  = req.req_type;
          rm_cnt_next    = '0;
          fired_next     = '0;
          pend_next      = 1'b0;
          tick_mode_next = 1'b0;
          cmd.load_req   = 1'b1;
          cmd.k_clr      = 1'b1;
          case (req.req_type)
            REQ_TICK: begin
              cmd.tick_dec   = 1'b1;
              tick_mode_next = 1'b1;
              state_next     = ST_TICK_CHECK;
            end
            REQ_POST:                state_next = ST_POST_WALK;
            REQ_RESTART, REQ_REMOVE: state_next = ST_REMOVE_WALK;
            REQ_REMOVE_ALL: begin
              cmd.clear_all          = 1'b1;
              emit                   = 1'b1;
              res_next.result_kind   = RES_REMOVED;
              res_next.removed_count = sat5(count);
            end
            REQ_QUERY:               state_next = ST_QUERY_WALK;
            default:                 state_next = ST_IDLE;
          endcase
        end
      end

      ST_TICK_CHECK: begin
        if (stat.head_zero && fired < FIRED_W'(MAX_RESULTS)) begin
          // The expiry held from the previous pop is now known not to be last.
          if (pend) begin
            emit                 = 1'b1;
            res_next.result_kind = RES_EXPIRY;
            res_next.fired_task  = stat.op_task;
            res_next.fired_param = stat.op_param;
            res_next.last        = 1'b0;
          end
          cmd.load_head = 1'b1;
          cmd.drop      = 1'b1;
          cmd.drop_head = 1'b1;
          cmd.k_clr     = 1'b1;
          fired_next    = fired + FIRED_W'(1);
          pend_next     = 1'b1;
          state_next    = stat.head_rep_nz ? ST_POST_WALK : ST_TICK_CHECK;
        end else begin
          emit = 1'b1;
          if (pend) begin
            res_next.result_kind = RES_EXPIRY;
            res_next.fired_task  = stat.op_task;
            res_next.fired_param = stat.op_param;
          end else begin
            res_next.result_kind = RES_TICK_IDLE;
          end
          pend_next  = 1'b0;
          state_next = ST_IDLE;
        end
      end

      ST_POST_WALK: begin
        if (stat.full) begin
          emit                   = 1'b1;
          res_next.result_kind   = RES_POST_ACK;
          res_next.removed_count = sat5(rm_cnt);
          state_next             = ST_IDLE;
        end else if (stat.k_lt_count && stat.rest_gt) begin
          cmd.rest_sub = 1'b1;
          cmd.k_inc    = 1'b1;
        end else begin
          cmd.insert = 1'b1;
          if (tick_mode) begin
            state_next = ST_TICK_CHECK;
          end else begin
            emit                   = 1'b1;
            res_next.result_kind   = RES_POST_ACK;
            res_next.ok            = 1'b1;
            res_next.removed_count = sat5(rm_cnt);
            state_next             = ST_IDLE;
          end
        end
      end

      ST_REMOVE_WALK: begin
        if (stat.k_lt_count) begin
          if (stat.id_match) begin
            cmd.drop    = 1'b1;
            rm_cnt_next = rm_cnt + CNT_W'(1);
          end else begin
            cmd.k_inc = 1'b1;
          end
        end else if (req_kind == REQ_RESTART) begin
          cmd.k_clr  = 1'b1;
          state_next = ST_POST_WALK;
        end else begin
          emit                   = 1'b1;
          res_next.result_kind   = RES_REMOVED;
          res_next.removed_count = sat5(rm_cnt);
          state_next             = ST_IDLE;
        end
      end

      ST_QUERY_WALK: begin
        if (stat.k_lt_count && !stat.id_match) begin
          cmd.k_inc = 1'b1;
        end else begin
          emit                 = 1'b1;
          res_next.result_kind = RES_QUERY;
          res_next.ok          = stat.k_lt_count;
          state_next           = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: hdl/delta_list_timer_queue_core.sv
// Timing: post, remove and query are set by the one-entry-per-cycle list walk;
// restart walks the list to remove and again to re-insert, and a tick walks it
// to re-insert each periodic timer that fires; remove-all does not walk or raise
// busy, and for every other request busy stays high until the last result.
// Throughput: one transaction at a time.
// Reset clears the list (entry count zero) and the controller returns to idle.
// ----------------------------------------------------------------------------
// Delta-list timer queue core
// Sorted delta-list of timers with post, restart, remove, remove-all, query
// and tick requests; expiries come one per cycle, stalled by periodic re-inserts.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_core
  import dltq_pkg::*;
#(
  parameter int TIMER_SLOTS = 16,
  parameter int COUNT_BITS  = 16,
  parameter int PARAM_BITS  = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  req_t    req,
  output logic    busy,
  output logic    strobe,
  output result_t result
);

  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

  cmd_t             cmd;
  stat_t            stat;
  logic [CNT_W-1:0] count;

  dltq_ctrl #(
    .TIMER_SLOTS(TIMER_SLOTS)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .busy  (busy),
    .strobe(strobe),
    .result(result),
    .cmd   (cmd),
    .stat  (stat),
    .count (count)
  );

  dltq_datapath #(
    .TIMER_SLOTS(TIMER_SLOTS),
    .COUNT_BITS (COUNT_BITS),
    .PARAM_BITS (PARAM_BITS)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .count(count)
  );

endmodule
